/* rtl/lfr_pkg.sv */
// lfr_pkg: shared types and constants for the lru frame replacement block
// used by lfr_store and lru_frame_replacement; depends on nothing else
package lfr_pkg;

    // width of a physical frame number and the largest order the store holds
    localparam int FRAME_W        = 6;
    localparam int STORE_DEPTH    = 64;
    localparam int FRAMES_DEFAULT = 64;

    typedef logic [FRAME_W-1:0] frame_t;

    // command codes
    localparam logic CMD_REF   = 1'b0;
    localparam logic CMD_EVICT = 1'b1;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FIN  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

endpackage

/* rtl/lru_frame_replacement.sv */
// lru_frame_replacement: recency order of physical frames, oldest first.
// Input channel (in_valid/in_ready) carries cmd and frame_number. A reference
// (cmd 0) moves the frame to the newest end, or appends it if it is not
// listed; a full order ignores a new frame. A reference gives no transfer on
// the output. An evict (cmd 1) removes the oldest frame and sends one transfer
// on the output channel (out_valid/out_ready) with victim_frame and
// order_empty; an evict on an empty order returns frame 0 with order_empty set.
// One compare unit walks the stored entries one per cycle through the single
// read port of the order memory, shifting younger entries down behind a match.
// A reference passes from S_SCAN (skipped on an empty order) to S_FIN, which
// writes the newest entry unless a full order ignores the frame; in_ready is
// high again once it returns to S_IDLE. An evict passes through S_SCAN
// (skipped on an empty order), S_FIN and S_OUT, and S_OUT loads the output
// register. A result waits in that register while the receiver stalls; the
// block keeps taking items, and an evict that finishes while the register is
// full holds until it is taken. Reset empties the order at once; the memory
// itself is not cleared. Depends on lfr_pkg and lfr_store.
module lru_frame_replacement #(
    parameter int FRAMES = lfr_pkg::FRAMES_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            cmd,
    input  lfr_pkg::frame_t frame_number,
    output logic            out_valid,
    input  logic            out_ready,
    output lfr_pkg::frame_t victim_frame,
    output logic            order_empty
);
    import lfr_pkg::*;

    localparam int DEPTH = (FRAMES < STORE_DEPTH) ? FRAMES : STORE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [CW-1:0]   rd_cnt_reg, rd_cnt_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [AW-1:0]   pend_idx_reg, pend_idx_next;
    logic            found_reg, found_next;
    logic            cmd_reg, cmd_next;
    frame_t          fr_reg, fr_next;
    frame_t          victim_reg, victim_next;
    logic            out_valid_reg, out_valid_next;
    frame_t          out_victim_reg, out_victim_next;
    logic            out_empty_reg, out_empty_next;

    logic            in_xfer;
    logic            out_free;
    logic            rd_en;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    frame_t          wr_data;
    frame_t          rd_data;
    logic            match;
    logic [CW-1:0]   last_idx;

    // order memory
    lfr_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_cnt_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign last_idx  = n_reg - CW'(1);

    // shared compare unit: the entry that leaves for an evict, or the named frame
    assign match = (cmd_reg == CMD_EVICT) ? (pend_idx_reg == '0) : (rd_data == fr_reg);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        rd_cnt_next     = rd_cnt_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        cmd_next        = cmd_reg;
        fr_next         = fr_reg;
        victim_next     = victim_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_victim_next = out_victim_reg;
        out_empty_next  = out_empty_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = fr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next    = cmd;
                    fr_next     = frame_number;
                    n_next      = count_reg;
                    rd_cnt_next = '0;
                    found_next  = 1'b0;
                    state_next  = (count_reg == '0) ? S_FIN : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // issue the next read
                if (rd_cnt_reg < n_reg)
                begin
                    rd_en           = 1'b1;
                    rd_cnt_next     = rd_cnt_reg + CW'(1);
                    pend_valid_next = 1'b1;
                    pend_idx_next   = rd_cnt_reg[AW-1:0];
                end
                else
                begin
                    state_next = S_FIN;
                end
                // handle the entry read in the previous cycle
                if (pend_valid_reg)
                begin
                    if (!found_reg && match)
                    begin
                        found_next  = 1'b1;
                        victim_next = rd_data;
                    end
                    else if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = pend_idx_reg - AW'(1);
                        wr_data = rd_data;
                    end
                end
            end

            S_FIN:
            begin
                if (cmd_reg == CMD_REF)
                begin
                    state_next = S_IDLE;
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = last_idx[AW-1:0];
                    end
                    else if (n_reg < CW'(DEPTH))
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = n_reg[AW-1:0];
                        count_next = count_reg + CW'(1);
                    end
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                // evict result waits for a free output register
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (n_reg == '0)
                    begin
                        out_victim_next = '0;
                        out_empty_next  = 1'b1;
                    end
                    else
                    begin
                        out_victim_next = victim_reg;
                        out_empty_next  = 1'b0;
                        count_next      = count_reg - CW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        rd_cnt_reg     <= rd_cnt_next;
        pend_idx_reg   <= pend_idx_next;
        found_reg      <= found_next;
        cmd_reg        <= cmd_next;
        fr_reg         <= fr_next;
        victim_reg     <= victim_next;
        out_victim_reg <= out_victim_next;
        out_empty_reg  <= out_empty_next;
    end

    assign out_valid    = out_valid_reg;
    assign victim_frame = out_victim_reg;
    assign order_empty  = out_empty_reg;

`ifndef SYNTH
    // the order never holds more entries than the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above capacity");

    // a result appears only after an evict in the output state
    a_out_from_evict: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT && cmd_reg == CMD_EVICT))
        else $error("result without evict");

    // the memory is never written while idle
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg != S_IDLE)
        else $error("memory write while idle");

    // the read walk never passes the stored entries
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> rd_cnt_reg <= n_reg)
        else $error("scan beyond entry count");

    // an empty evict result always names frame zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_empty_reg |-> out_victim_reg == '0)
        else $error("empty result with nonzero frame");
`endif

endmodule

/* rtl/lfr_store.sv */
// lfr_store: recency order memory, one write port and one registered read port
// depends on lfr_pkg for the frame type
module lfr_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  lfr_pkg::frame_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output lfr_pkg::frame_t rd_data
);
    import lfr_pkg::*;

    frame_t mem [DEPTH];
    frame_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// tb: self-checking testbench for lru_frame_replacement (reference and evict traffic)
// depends on lfr_pkg and lru_frame_replacement; holds its own recency-order predictor

import lfr_pkg::*;

// expected evict result
typedef struct {
    frame_t victim;
    logic   empty;
} victim_rec_t;

// tracks the recency order and the victims that evicts still owe
class lru_order_tracker;
    frame_t      order_q[64];
    int unsigned listed;
    int unsigned capacity;
    victim_rec_t victims_due[$];
    int          errors;

    function new(int unsigned frames);
        capacity = (frames < 64) ? frames : 64;
        listed   = 0;
        errors   = 0;
        foreach (order_q[i]) order_q[i] = '0;
    endfunction

    // one line per mismatch, counted
    task report_mismatch(string msg);
        errors++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // an input transfer was accepted: update the order, queue any victim
    function void note_transfer(logic c, frame_t f);
        int unsigned pos;
        victim_rec_t rec;
        if (c == CMD_REF)
        begin
            pos = listed;
            for (int unsigned i = 0; i < listed; i++)
            begin
                if (order_q[i] == f)
                begin
                    pos = i;
                    break;
                end
            end
            if (pos < listed)
            begin
                // move to the newest end
                for (int unsigned i = pos; i + 1 < listed; i++)
                    order_q[i] = order_q[i + 1];
                order_q[listed - 1] = f;
            end
            else if (listed < capacity)
            begin
                order_q[listed] = f;
                listed++;
            end
        end
        else
        begin
            if (listed == 0)
            begin
                rec.victim = '0;
                rec.empty  = 1'b1;
            end
            else
            begin
                rec.victim = order_q[0];
                rec.empty  = 1'b0;
                for (int unsigned i = 0; i + 1 < listed; i++)
                    order_q[i] = order_q[i + 1];
                listed--;
            end
            victims_due.push_back(rec);
        end
    endfunction

    // an output transfer was accepted: compare with the oldest victim due
    task check_victim(frame_t v, logic e);
        victim_rec_t rec;
        if (victims_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected victim %0d empty %0b", v, e));
        end
        else
        begin
            rec = victims_due.pop_front();
            if (v !== rec.victim)
                report_mismatch($sformatf("victim_frame %0d, want %0d", v, rec.victim));
            if (e !== rec.empty)
                report_mismatch($sformatf("order_empty %0b, want %0b", e, rec.empty));
        end
    endtask

    function int pending();
        return victims_due.size();
    endfunction
endclass

module tb;

    localparam int RANDOM_ITEMS   = 800;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 80;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    logic   cmd;
    frame_t frame_number;
    logic   out_valid;
    logic   out_ready;
    frame_t victim_frame;
    logic   order_empty;

    // no idling on either side while set
    logic   calm;

    lru_order_tracker tracker;

    lru_frame_replacement dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .frame_number (frame_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .victim_frame (victim_frame),
        .order_empty  (order_empty)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // drive one item and wait for its transfer
    task send_item(input logic c, input frame_t f);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            cmd          <= 1'($urandom_range(1));
            frame_number <= frame_t'($urandom_range(63));
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        frame_number <= f;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_transfer(c, f);
    endtask

    // reference every frame once, in shuffled order
    task sweep_all_frames();
        frame_t perm[64];
        frame_t tmp;
        int     j;
        foreach (perm[i]) perm[i] = frame_t'(i);
        for (int i = 63; i > 0; i--)
        begin
            j       = $urandom_range(i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        foreach (perm[i]) send_item(CMD_REF, perm[i]);
    endtask

    // receiver stalls
    always @(negedge clk)
    begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 20);
    end

    // output transfers
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_victim(victim_frame, order_empty);
    end

    // watchdog: cycles with no transfer on either channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus
    initial
    begin
        int          done;
        int          phase;
        int unsigned pool;
        int unsigned evict_pct;
        frame_t      f;

        tracker      = new(FRAMES_DEFAULT);
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = CMD_REF;
        frame_number = '0;
        out_ready    = 1'b0;
        calm         = 1'b0;
        @(posedge clk);
        @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty evicts, field extremes, newest, oldest and middle moves
        send_item(CMD_EVICT, 6'd0);
        send_item(CMD_EVICT, 6'd63);
        send_item(CMD_REF, 6'd0);
        send_item(CMD_REF, 6'd63);
        send_item(CMD_REF, 6'd63);
        send_item(CMD_REF, 6'd0);
        send_item(CMD_REF, 6'd21);
        send_item(CMD_REF, 6'd42);
        send_item(CMD_REF, 6'd63);
        send_item(CMD_REF, 6'd21);
        send_item(CMD_EVICT, 6'd42);
        send_item(CMD_EVICT, 6'd0);
        send_item(CMD_EVICT, 6'd63);
        send_item(CMD_EVICT, 6'd21);
        send_item(CMD_EVICT, 6'd0);
        send_item(CMD_REF, 6'd42);
        send_item(CMD_EVICT, 6'd63);
        send_item(CMD_EVICT, 6'd42);

        // random: phases vary the frame pool and the evict rate
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            phase = done / 100;
            calm  = (done >= 300 && done < 450);
            if (done % 100 == 0 && (phase == 2 || phase == 5))
            begin
                // fill the order completely, referencing every frame once
                sweep_all_frames();
                done += 64;
            end
            else if (done % 100 == 0 && (phase == 4 || phase == 7))
            begin
                // drain past empty
                repeat (70) send_item(CMD_EVICT, frame_t'($urandom_range(63)));
                done += 70;
            end
            else
            begin
                case (phase % 4)
                    0:       begin pool = 4;  evict_pct = 30; end
                    1:       begin pool = 16; evict_pct = 20; end
                    2:       begin pool = 64; evict_pct = 10; end
                    default: begin pool = 64; evict_pct = 50; end
                endcase
                f = frame_t'($urandom_range(pool - 1));
                if ($urandom_range(99) < evict_pct)
                    send_item(CMD_EVICT, frame_t'($urandom_range(63)));
                else
                    send_item(CMD_REF, f);
                done++;
            end
        end
        calm = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        // wait for every victim, then for any late result
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.report_mismatch("victims still due at end of run");

        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
